>>> design/tcf_pkg.sv
package tcf_pkg;

    localparam int TAPS       = 8;
    localparam int NUM_COEFS  = 8;
    localparam int PTR_W      = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int CIDX_W     = 3;
    localparam int SAMPLE_W   = 32;
    localparam int COEF_W     = 18;
    localparam int PROD_W     = SAMPLE_W + COEF_W;
    localparam int ACC_W      = PROD_W + 3;
    localparam int FRAC_W     = 16;
    localparam int Q_W        = ACC_W - FRAC_W;
    localparam int ROUND_BIAS = 2 ** (FRAC_W - 1);

    localparam logic [PTR_W:0] TAPS_EXT = (PTR_W + 1)'(TAPS);
    localparam logic [PTR_W-1:0] LAST_TAP = PTR_W'(TAPS - 1);

    localparam logic signed [COEF_W-1:0] COEF_RESET [NUM_COEFS] = '{
        18'sd65536, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0
    };

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] x;
        logic signed [SAMPLE_W-1:0] y;
        logic signed [SAMPLE_W-1:0] z;
    } sample_t;

    typedef struct packed {
        logic                     valid;
        logic                     first;
        logic                     last;
        logic signed [COEF_W-1:0] coef;
    } issue_t;

    function automatic logic signed [SAMPLE_W-1:0] round_sat(
        input logic signed [ACC_W-1:0] acc
    );
        logic [ACC_W-1:0] biased;
        logic [Q_W-1:0]   q;
        logic             fits;
        biased = acc + ACC_W'(ROUND_BIAS);
        q      = biased[ACC_W-1:FRAC_W];
        fits   = (&q[Q_W-1:SAMPLE_W-1]) || !(|q[Q_W-1:SAMPLE_W-1]);
        if (fits)
        begin
            round_sat = q[SAMPLE_W-1:0];
        end
        else if (q[Q_W-1])
        begin
            round_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end
        else
        begin
            round_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
    endfunction

endpackage

>>> design/tcf_ifs.sv
interface tcf_sample_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [tcf_pkg::SAMPLE_W-1:0]    sample_x;
    logic signed [tcf_pkg::SAMPLE_W-1:0]    sample_y;
    logic signed [tcf_pkg::SAMPLE_W-1:0]    sample_z;

    modport source (output valid, output sample_x, output sample_y, output sample_z,
                    input ready);
    modport sink   (input valid, input sample_x, input sample_y, input sample_z,
                    output ready);
endinterface

interface tcf_result_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [tcf_pkg::SAMPLE_W-1:0]    filtered_x;
    logic signed [tcf_pkg::SAMPLE_W-1:0]    filtered_y;
    logic signed [tcf_pkg::SAMPLE_W-1:0]    filtered_z;

    modport source (output valid, output filtered_x, output filtered_y, output filtered_z,
                    input ready);
    modport sink   (input valid, input filtered_x, input filtered_y, input filtered_z,
                    output ready);
endinterface

>>> design/tcf_hist_mem.sv
module tcf_hist_mem (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_en,
    input  logic [tcf_pkg::PTR_W-1:0]   wr_addr,
    input  tcf_pkg::sample_t            wr_data,
    input  logic                        rd_en,
    input  logic [tcf_pkg::PTR_W-1:0]   rd_addr,
    output tcf_pkg::sample_t            rd_data
);

    tcf_pkg::sample_t                   hist_mem [tcf_pkg::TAPS];
    logic [tcf_pkg::TAPS-1:0]           vld_reg;
    tcf_pkg::sample_t                   rd_data_reg;

    // entries never written read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (wr_en)
        begin
            vld_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            hist_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= vld_reg[rd_addr] ? hist_mem[rd_addr] : '0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/tcf_mac.sv
module tcf_mac (
    input  logic                clk,
    input  logic                rst_n,
    input  tcf_pkg::issue_t     issue,
    input  tcf_pkg::sample_t    rd_data,
    output logic                done,
    output tcf_pkg::sample_t    result
);

    tcf_pkg::issue_t                            s1_reg;
    logic                                       s2_v_reg;
    logic                                       s2_first_reg;
    logic                                       s2_last_reg;
    logic                                       done_reg;
    logic signed [tcf_pkg::PROD_W-1:0]          prod_x_reg;
    logic signed [tcf_pkg::PROD_W-1:0]          prod_y_reg;
    logic signed [tcf_pkg::PROD_W-1:0]          prod_z_reg;
    logic signed [tcf_pkg::ACC_W-1:0]           acc_x_reg;
    logic signed [tcf_pkg::ACC_W-1:0]           acc_y_reg;
    logic signed [tcf_pkg::ACC_W-1:0]           acc_z_reg;
    logic signed [tcf_pkg::ACC_W-1:0]           acc_x_next;
    logic signed [tcf_pkg::ACC_W-1:0]           acc_y_next;
    logic signed [tcf_pkg::ACC_W-1:0]           acc_z_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg       <= '0;
            s2_v_reg     <= 1'b0;
            s2_first_reg <= 1'b0;
            s2_last_reg  <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_reg       <= issue;
            s2_v_reg     <= s1_reg.valid;
            s2_first_reg <= s1_reg.first;
            s2_last_reg  <= s1_reg.last;
            done_reg     <= s2_v_reg && s2_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_x_reg  <= rd_data.x * s1_reg.coef;
        prod_y_reg  <= rd_data.y * s1_reg.coef;
        prod_z_reg  <= rd_data.z * s1_reg.coef;
        if (s2_v_reg)
        begin
            acc_x_reg <= acc_x_next;
            acc_y_reg <= acc_y_next;
            acc_z_reg <= acc_z_next;
        end
    end

    always_comb
    begin
        acc_x_next = (s2_first_reg ? '0 : acc_x_reg) + tcf_pkg::ACC_W'(prod_x_reg);
        acc_y_next = (s2_first_reg ? '0 : acc_y_reg) + tcf_pkg::ACC_W'(prod_y_reg);
        acc_z_next = (s2_first_reg ? '0 : acc_z_reg) + tcf_pkg::ACC_W'(prod_z_reg);
    end

    assign done     = done_reg;
    assign result.x = tcf_pkg::round_sat(acc_x_reg);
    assign result.y = tcf_pkg::round_sat(acc_y_reg);
    assign result.z = tcf_pkg::round_sat(acc_z_reg);

endmodule

>>> design/three_channel_fir_filter_unit.sv
// Three-channel 8-tap FIR filter, Q16.16 samples, Q2.16 coefficients.
// samples: valid/ready channel carrying one x,y,z triple per transaction.
// results: valid/ready channel returning one filtered triple per input.
// cfg_we/cfg_index/cfg_data write coefficient cfg_index; write only while idle.
// Each triple is written into a 3 x 32-bit wide history RAM, then the taps are
// read back one per cycle, newest first, through three 32x18 multipliers and
// 53-bit accumulators, then rounded half up and saturated to 32 bits.
// A new triple is accepted only while idle, once the previous sum has moved from the
// accumulators into the output register.
// Reset: history reads as zero, write pointer at slot 0, coef_0 = 1.0 and
// all other coefficients zero.
// A finished triple sits in the output register until taken; the next input
// is accepted meanwhile, and its sum is held in the accumulators until the
// output register frees.
module three_channel_fir_filter_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    tcf_sample_if.sink                      samples,
    tcf_result_if.source                    results,
    input  logic                            cfg_we,
    input  logic [tcf_pkg::CIDX_W-1:0]      cfg_index,
    input  logic [tcf_pkg::COEF_W-1:0]      cfg_data
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0]                             state_reg;
    logic [1:0]                             state_next;
    logic [tcf_pkg::PTR_W-1:0]              pos_reg;
    logic [tcf_pkg::PTR_W-1:0]              pos_next;
    logic [tcf_pkg::PTR_W-1:0]              tap_reg;
    logic [tcf_pkg::PTR_W-1:0]              tap_next;
    logic                                   acc_full_reg;
    logic                                   acc_full_next;
    logic                                   out_valid_reg;
    logic                                   out_valid_next;
    tcf_pkg::sample_t                       out_data_reg;
    logic signed [tcf_pkg::COEF_W-1:0]      coef_reg [tcf_pkg::NUM_COEFS];

    logic                                   in_accept;
    logic                                   out_load;
    logic [tcf_pkg::PTR_W:0]                addr_sum;
    logic [tcf_pkg::PTR_W-1:0]              rd_addr;
    tcf_pkg::issue_t                        issue;
    tcf_pkg::sample_t                       wr_data;
    tcf_pkg::sample_t                       rd_data;
    tcf_pkg::sample_t                       mac_result;
    logic                                   mac_done;

    assign samples.ready = (state_reg == ST_IDLE);
    assign in_accept     = samples.valid && samples.ready;
    assign out_load      = (state_reg == ST_DRAIN) && acc_full_reg
                           && (!out_valid_reg || results.ready);

    assign wr_data.x = samples.sample_x;
    assign wr_data.y = samples.sample_y;
    assign wr_data.z = samples.sample_z;

    // slot of the sample tap_reg steps back
    always_comb
    begin
        addr_sum = {1'b0, pos_reg} + tcf_pkg::TAPS_EXT - {1'b0, tap_reg};
        if (addr_sum >= tcf_pkg::TAPS_EXT)
        begin
            addr_sum = addr_sum - tcf_pkg::TAPS_EXT;
        end
        rd_addr = addr_sum[tcf_pkg::PTR_W-1:0];
    end

    always_comb
    begin
        issue.valid = (state_reg == ST_RUN);
        issue.first = (tap_reg == '0);
        issue.last  = (tap_reg == tcf_pkg::LAST_TAP);
        issue.coef  = coef_reg[tcf_pkg::CIDX_W'(tap_reg)];
    end

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        tap_next       = tap_reg;
        acc_full_next  = acc_full_reg;
        out_valid_next = out_valid_reg;
        if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (mac_done)
        begin
            acc_full_next = 1'b1;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_RUN;
                    tap_next   = '0;
                end
            end
            ST_RUN:
            begin
                if (tap_reg == tcf_pkg::LAST_TAP)
                begin
                    state_next = ST_DRAIN;
                    tap_next   = '0;
                    pos_next   = (pos_reg == tcf_pkg::LAST_TAP) ? '0 : pos_reg + 1'b1;
                end
                else
                begin
                    tap_next = tap_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (out_load)
                begin
                    state_next     = ST_IDLE;
                    acc_full_next  = 1'b0;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            tap_reg       <= '0;
            acc_full_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < tcf_pkg::NUM_COEFS; i++)
            begin
                coef_reg[i] <= tcf_pkg::COEF_RESET[i];
            end
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            tap_reg       <= tap_next;
            acc_full_reg  <= acc_full_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                coef_reg[cfg_index] <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= mac_result;
        end
    end

    assign results.valid      = out_valid_reg;
    assign results.filtered_x = out_data_reg.x;
    assign results.filtered_y = out_data_reg.y;
    assign results.filtered_z = out_data_reg.z;

    tcf_hist_mem u_hist_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (in_accept),
        .wr_addr (pos_reg),
        .wr_data (wr_data),
        .rd_en   (issue.valid),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    tcf_mac u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .issue   (issue),
        .rd_data (rd_data),
        .done    (mac_done),
        .result  (mac_result)
    );

    a_accept_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == ST_RUN) && (tap_reg == '0))
        else $error("transaction accepted but tap sequence did not start");

    a_done_only_draining: assert property (@(posedge clk) disable iff (!rst_n)
        mac_done |-> (state_reg == ST_DRAIN) && !acc_full_reg)
        else $error("accumulator finished outside drain or overwrote a held sum");

    a_load_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> results.valid && (state_reg == ST_IDLE) && !acc_full_reg)
        else $error("result load did not present a transaction");

    a_pos_steps_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_RUN) |=> (pos_reg == $past(pos_reg)))
        else $error("write pointer moved outside the tap sequence");

endmodule

>>> bench/tb_three_channel_fir_filter_unit.sv
module tb_three_channel_fir_filter_unit;

    localparam logic signed [tcf_pkg::SAMPLE_W-1:0] S_MAX = 32'sh7fff_ffff;
    localparam logic signed [tcf_pkg::SAMPLE_W-1:0] S_MIN = 32'sh8000_0000;
    localparam logic signed [tcf_pkg::COEF_W-1:0]   C_MAX = 18'sh1ffff;
    localparam logic signed [tcf_pkg::COEF_W-1:0]   C_MIN = 18'sh20000;
    localparam logic signed [tcf_pkg::COEF_W-1:0]   C_ONE = 18'sd65536;
    localparam longint SAT_HI       = 64'sd2147483647;
    localparam longint SAT_LO       = -64'sd2147483648;
    localparam int     CYCLE_LIMIT  = 400000;
    localparam int     RAND_PHASES  = 10;
    localparam int     PHASE_ITEMS  = 85;

    class fir_model;
        logic signed [tcf_pkg::COEF_W-1:0]   coef [tcf_pkg::NUM_COEFS];
        logic signed [tcf_pkg::SAMPLE_W-1:0] hist [3][tcf_pkg::TAPS];
        int unsigned                         wr_pos;
        tcf_pkg::sample_t                    pending_filtered [$];
        int                                  errors;

        function new();
            foreach (coef[i]) coef[i] = tcf_pkg::COEF_RESET[i];
            foreach (hist[c, k]) hist[c][k] = '0;
            wr_pos = 0;
            errors = 0;
        endfunction

        function void set_coef(int idx, logic signed [tcf_pkg::COEF_W-1:0] value);
            if (idx < tcf_pkg::NUM_COEFS)
            begin
                coef[idx] = value;
            end
        endfunction

        function int pending();
            return pending_filtered.size();
        endfunction

        function logic signed [tcf_pkg::SAMPLE_W-1:0] filter_channel(int ch);
            longint acc;
            int     k;
            acc = 0;
            for (k = 0; k < tcf_pkg::TAPS; k++)
            begin
                acc += longint'(hist[ch][(wr_pos + tcf_pkg::TAPS - k) % tcf_pkg::TAPS])
                       * longint'(coef[k]);
            end
            acc = (acc + 64'sd32768) >>> tcf_pkg::FRAC_W;
            if (acc > SAT_HI)
            begin
                return S_MAX;
            end
            if (acc < SAT_LO)
            begin
                return S_MIN;
            end
            return acc[tcf_pkg::SAMPLE_W-1:0];
        endfunction

        function void note_sample(tcf_pkg::sample_t s);
            tcf_pkg::sample_t e;
            hist[0][wr_pos] = s.x;
            hist[1][wr_pos] = s.y;
            hist[2][wr_pos] = s.z;
            e.x = filter_channel(0);
            e.y = filter_channel(1);
            e.z = filter_channel(2);
            pending_filtered.push_back(e);
            wr_pos = (wr_pos + 1) % tcf_pkg::TAPS;
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_result(logic signed [tcf_pkg::SAMPLE_W-1:0] fx,
                          logic signed [tcf_pkg::SAMPLE_W-1:0] fy,
                          logic signed [tcf_pkg::SAMPLE_W-1:0] fz);
            tcf_pkg::sample_t e;
            if (pending_filtered.size() == 0)
            begin
                report($sformatf("unexpected result %h %h %h", fx, fy, fz));
                return;
            end
            e = pending_filtered.pop_front();
            if (fx !== e.x)
            begin
                report($sformatf("filtered_x expected %h got %h", e.x, fx));
            end
            if (fy !== e.y)
            begin
                report($sformatf("filtered_y expected %h got %h", e.y, fy));
            end
            if (fz !== e.z)
            begin
                report($sformatf("filtered_z expected %h got %h", e.z, fz));
            end
        endtask
    endclass

    logic                              clk = 1'b0;
    logic                              rst_n;
    logic                              cfg_we;
    logic [tcf_pkg::CIDX_W-1:0]        cfg_index;
    logic [tcf_pkg::COEF_W-1:0]        cfg_data;

    tcf_sample_if sample_ch();
    tcf_result_if result_ch();

    fir_model                          model;
    tcf_pkg::sample_t                  phase_items [$];
    logic signed [tcf_pkg::COEF_W-1:0] next_coef [tcf_pkg::NUM_COEFS];
    int                                cycles = 0;
    int                                stall_mode = 0;
    int                                mode_left = 0;

    three_channel_fir_filter_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (sample_ch),
        .results   (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // result monitor, receiver stall pattern and run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[three_channel_fir_filter_unit] ERROR");
            $finish;
        end
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            model.check_result(result_ch.filtered_x, result_ch.filtered_y,
                               result_ch.filtered_z);
        end
        if (mode_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            mode_left  <= $urandom_range(50, 300);
        end
        else
        begin
            mode_left <= mode_left - 1;
        end
        case (stall_mode)
            0:       result_ch.ready <= 1'b1;
            1:       result_ch.ready <= ($urandom_range(0, 1) == 0);
            2:       result_ch.ready <= ($urandom_range(0, 3) != 0);
            default: result_ch.ready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    function automatic tcf_pkg::sample_t make_triple(logic signed [tcf_pkg::SAMPLE_W-1:0] x,
                                                     logic signed [tcf_pkg::SAMPLE_W-1:0] y,
                                                     logic signed [tcf_pkg::SAMPLE_W-1:0] z);
        tcf_pkg::sample_t s;
        s.x = x;
        s.y = y;
        s.z = z;
        return s;
    endfunction

    function automatic logic signed [tcf_pkg::SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            4, 5:       return $signed($urandom_range(0, 2 ** 21)) - 2 ** 20;
            6:          return $signed($urandom_range(0, 2 ** 28)) - 2 ** 27;
            7:          return ($signed($urandom_range(0, 2 ** 12)) - 2 ** 11) * 65536
                               + $signed($urandom_range(0, 2)) * 32768 - 32768;
            default:
            begin
                case ($urandom_range(0, 5))
                    0:       return S_MAX;
                    1:       return S_MIN;
                    2:       return 0;
                    3:       return 1;
                    4:       return -1;
                    default: return 32768;
                endcase
            end
        endcase
    endfunction

    function automatic logic signed [tcf_pkg::COEF_W-1:0] rand_coef(int mode, int k, int used);
        case (mode)
            0: return tcf_pkg::COEF_W'($urandom);
            1:
            begin
                case ($urandom_range(0, 6))
                    0:       return C_MAX;
                    1:       return C_MIN;
                    2:       return '0;
                    3:       return C_ONE;
                    4:       return -C_ONE;
                    5:       return tcf_pkg::COEF_W'(1);
                    default: return tcf_pkg::COEF_W'(-1);
                endcase
            end
            2:       return (k < used)
                            ? tcf_pkg::COEF_W'($signed($urandom_range(0, 65536)) - 32768)
                            : '0;
            default: return (k == 0)
                            ? tcf_pkg::COEF_W'($urandom)
                            : tcf_pkg::COEF_W'($signed($urandom_range(0, 4096)) - 2048);
        endcase
    endfunction

    task automatic wait_drained();
        while (model.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_coefs();
        int i;
        for (i = 0; i < tcf_pkg::NUM_COEFS; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= tcf_pkg::CIDX_W'(i);
            cfg_data  <= next_coef[i];
            @(posedge clk);
            model.set_coef(i, next_coef[i]);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic send_sample(tcf_pkg::sample_t s);
        sample_ch.valid    <= 1'b1;
        sample_ch.sample_x <= s.x;
        sample_ch.sample_y <= s.y;
        sample_ch.sample_z <= s.z;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        model.note_sample(s);
    endtask

    task automatic send_phase();
        int n;
        int burst;
        n = 0;
        while (n < phase_items.size())
        begin
            burst = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 20);
            while (burst > 0 && n < phase_items.size())
            begin
                send_sample(phase_items[n]);
                n++;
                burst--;
            end
            if ($urandom_range(0, 3) != 0)
            begin
                sample_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
                if ($urandom_range(0, 24) == 0)
                begin
                    wait_drained();
                end
            end
        end
        sample_ch.valid <= 1'b0;
        phase_items.delete();
    endtask

    task automatic set_all_coefs(logic signed [tcf_pkg::COEF_W-1:0] value);
        foreach (next_coef[i]) next_coef[i] = value;
    endtask

    initial
    begin
        int p;
        int i;
        int mode;
        int used;
        model              = new();
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        sample_ch.valid    = 1'b0;
        sample_ch.sample_x = '0;
        sample_ch.sample_y = '0;
        sample_ch.sample_z = '0;
        result_ch.ready    = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset coefficients: pass-through, history still zero
        phase_items.push_back(make_triple(0, 0, 0));
        phase_items.push_back(make_triple(S_MAX, S_MIN, 1));
        phase_items.push_back(make_triple(S_MIN, -1, S_MAX));
        phase_items.push_back(make_triple(32'shaaaa_aaaa, 32'sh5555_5555, 32'shaaaa_aaaa));
        phase_items.push_back(make_triple(32'sh5555_5555, 32'shaaaa_aaaa, 32'sh5555_5555));
        phase_items.push_back(make_triple(-1, 1, 0));
        phase_items.push_back(make_triple(rand_sample(), rand_sample(), rand_sample()));
        send_phase();

        // largest weights: positive and negative saturation
        wait_drained();
        set_all_coefs(C_MAX);
        write_coefs();
        for (i = 0; i < 5; i++)
        begin
            phase_items.push_back(make_triple(S_MAX, S_MIN, (i % 2 == 0) ? S_MAX : S_MIN));
        end
        send_phase();

        wait_drained();
        set_all_coefs(C_MIN);
        write_coefs();
        for (i = 0; i < 5; i++)
        begin
            phase_items.push_back(make_triple(S_MAX, S_MIN, 0));
        end
        send_phase();

        // smallest weight on the newest tap: round half up at the tie
        wait_drained();
        set_all_coefs('0);
        next_coef[0] = tcf_pkg::COEF_W'(1);
        write_coefs();
        phase_items.push_back(make_triple(32768, -32768, 65535));
        phase_items.push_back(make_triple(-32768, 32768, -65535));
        phase_items.push_back(make_triple(32767, -32769, 98304));
        phase_items.push_back(make_triple(-32769, 32767, -98304));
        phase_items.push_back(make_triple(98304, -98304, 0));
        send_phase();

        for (p = 0; p < RAND_PHASES; p++)
        begin
            wait_drained();
            mode = $urandom_range(0, 3);
            used = $urandom_range(1, tcf_pkg::TAPS);
            foreach (next_coef[k]) next_coef[k] = rand_coef(mode, k, used);
            write_coefs();
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                phase_items.push_back(make_triple(rand_sample(), rand_sample(), rand_sample()));
            end
            send_phase();
        end

        wait_drained();
        repeat (2 * tcf_pkg::TAPS + 8) @(posedge clk);
        if (model.errors == 0 && model.pending() == 0)
        begin
            $display("[three_channel_fir_filter_unit] OK");
        end
        else
        begin
            $display("[three_channel_fir_filter_unit] ERROR");
        end
        $finish;
    end

endmodule
